FILE: design/lru_pkg.sv
// Shared types and constants for the lru recency cache.
// No dependencies; imported by lru_cell and lru_recency_cache.
package lru_pkg;

    localparam int ID_W  = 31;
    localparam int POS_W = 3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_UPDATE,
        OP_ROTATE
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_EMIT
    } t_state;

    // broadcast control from the sequencer to every cell of the chain
    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
        logic            hit;
        logic            full;
        logic [ID_W-1:0] wrap_data;
    } t_cell_ctrl;

endpackage

FILE: design/lru_recency_cache.sv
// Top level of the lru recency cache: sequencer, output register and cell chain.
// Depends on lru_pkg and lru_cell.
//
// Input channel: i_valid / o_stall carry one page id per word. Output channel:
// o_valid / i_stall carry one list entry per word, oldest first, with the hit
// and eviction flags of the reference and o_last_entry on the final word.
// A reference first updates the cell chain (compare in every cell, shift toward
// the oldest end), then emits its list entries one by one: for each entry, the
// chain rotates by one cell and the oldest id goes to the output register.
// The next id is taken in the cycle the final entry is loaded, so a new
// reference can start its update while that entry waits in the output register.
// An accepted id is registered, the chain updates in S_UPDATE, and the entries
// are loaded into the output register in S_EMIT.
// When the receiver stalls, the output register holds its word and the chain
// stops rotating; o_stall stays high until the final entry is loaded.
// Reset clears the valid bit of every cell and the occupancy, so the cache
// comes up empty and needs no clearing pass.
module lru_recency_cache #(
    parameter int CAPACITY = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [lru_pkg::ID_W-1:0]  i_page_id,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [lru_pkg::ID_W-1:0]  o_entry_id,
    output logic [lru_pkg::POS_W-1:0] o_position,
    output logic                      o_was_hit,
    output logic                      o_evicted_valid,
    output logic [lru_pkg::ID_W-1:0]  o_evicted_id,
    output logic                      o_last_entry
);
    import lru_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state           r_state;
    t_state           n_state;
    t_cell_ctrl       ctrl;
    logic [ID_W-1:0]  r_id;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_occ;
    logic             r_hit;
    logic             r_ev_valid;
    logic [ID_W-1:0]  r_ev_id;

    logic             r_out_valid;
    logic [ID_W-1:0]  r_out_entry;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_hit;
    logic             r_out_ev_valid;
    logic [ID_W-1:0]  r_out_ev_id;
    logic             r_out_last;

    logic [ID_W-1:0]     cell_data  [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_match;

    logic hit;
    logic full;
    logic load;
    logic last;
    logic accept;

    assign hit    = cell_match[CAPACITY-1];
    assign full   = (r_occ == CNT_W'(CAPACITY));
    assign load   = (r_state == S_EMIT) && (!r_out_valid || !i_stall);
    assign last   = ((r_pos + CNT_W'(1)) == r_occ);
    assign o_stall = !((r_state == S_IDLE) || (load && last));
    assign accept = i_valid && !o_stall;

    always_comb begin
        n_state        = r_state;
        ctrl.op        = OP_HOLD;
        ctrl.id        = r_id;
        ctrl.hit       = hit;
        ctrl.full      = full;
        ctrl.wrap_data = cell_data[0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                ctrl.op = OP_UPDATE;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (load) begin
                    ctrl.op = OP_ROTATE;
                    if (last) begin
                        n_state = accept ? S_UPDATE : S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPDATE) begin
                r_pos <= '0;
                if (!hit && !full) begin
                    r_occ <= r_occ + CNT_W'(1);
                end
            end else if (load) begin
                r_pos <= r_pos + CNT_W'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id <= i_page_id;
        end
        if (r_state == S_UPDATE) begin
            r_hit      <= hit;
            r_ev_valid <= !hit && full;
            r_ev_id    <= (!hit && full) ? cell_data[0] : '0;
        end
        if (load) begin
            r_out_entry    <= cell_data[0];
            r_out_pos      <= POS_W'(r_pos);
            r_out_hit      <= r_hit;
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_id    <= r_ev_id;
            r_out_last     <= last;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ID_W-1:0] data_hi;
        logic            valid_hi;
        logic            valid_lo;
        logic            match_lo;

        if (g == CAPACITY - 1) begin : g_top
            assign data_hi  = '0;
            assign valid_hi = 1'b0;
        end else begin : g_mid
            assign data_hi  = cell_data[g+1];
            assign valid_hi = cell_valid[g+1];
        end

        if (g == 0) begin : g_bot
            assign valid_lo = 1'b1;
            assign match_lo = 1'b0;
        end else begin : g_up
            assign valid_lo = cell_valid[g-1];
            assign match_lo = cell_match[g-1];
        end

        lru_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_data_hi  (data_hi),
            .i_valid_hi (valid_hi),
            .i_valid_lo (valid_lo),
            .i_match_lo (match_lo),
            .o_data     (cell_data[g]),
            .o_valid    (cell_valid[g]),
            .o_match    (cell_match[g])
        );
    end

    assign o_valid         = r_out_valid;
    assign o_entry_id      = r_out_entry;
    assign o_position      = r_out_pos;
    assign o_was_hit       = r_out_hit;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_id    = r_out_ev_id;
    assign o_last_entry    = r_out_last;

    // valid cells stay packed at the oldest end and match the occupancy
    a_occ_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) == int'(r_occ))
        else $error("cell valid bits disagree with occupancy");

    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_occ != '0))
        else $error("emitting from an empty cache");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_was_hit && o_evicted_valid))
        else $error("hit and eviction on the same reference");

    a_update_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_UPDATE))
        else $error("accepted word not followed by update");

endmodule

FILE: design/lru_cell.sv
// One entry of the recency chain: holds an id and its valid bit.
// Depends on lru_pkg; instantiated in a row by lru_recency_cache.
module lru_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lru_pkg::t_cell_ctrl    i_ctrl,
    input  logic [lru_pkg::ID_W-1:0] i_data_hi,
    input  logic                   i_valid_hi,
    input  logic                   i_valid_lo,
    input  logic                   i_match_lo,
    output logic [lru_pkg::ID_W-1:0] o_data,
    output logic                   o_valid,
    output logic                   o_match
);
    import lru_pkg::*;

    logic [ID_W-1:0] r_data;
    logic [ID_W-1:0] n_data;
    logic            r_valid;
    logic            n_valid;
    logic            hit_here;
    logic            top;
    logic            shift;
    logic            first_free;

    assign hit_here   = r_valid && (r_data == i_ctrl.id);
    // match seen at or below this cell
    assign o_match    = i_match_lo | hit_here;
    assign top        = r_valid && !i_valid_hi;
    assign shift      = i_ctrl.hit ? o_match : i_ctrl.full;
    assign first_free = !r_valid && i_valid_lo;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        unique case (i_ctrl.op)
            OP_UPDATE: begin
                if (shift) begin
                    n_data = top ? i_ctrl.id : i_data_hi;
                end else if (!i_ctrl.hit && !i_ctrl.full && first_free) begin
                    n_data  = i_ctrl.id;
                    n_valid = 1'b1;
                end
            end
            OP_ROTATE: begin
                // newest valid cell takes the oldest id back
                if (r_valid) begin
                    n_data = top ? i_ctrl.wrap_data : i_data_hi;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

FILE: sim/lru_recency_cache_test.sv
// Testbench for lru_recency_cache: random page references against an lru list predictor.
// Depends on lru_pkg and the lru_recency_cache design files. It checks every list word
// field by field, with random idling on both sides, a long output stall and drain pauses.
`timescale 1ns / 1ps

module lru_recency_cache_test;
    import lru_pkg::*;

    localparam int CAPACITY     = 5;
    localparam int HOLD_AT      = 130;   // references taken before the long output stall
    localparam int HOLD_CYCLES  = 100;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 12;
    localparam int POOL_SIZE    = 7;

    typedef struct {
        logic [ID_W-1:0] id;
        int              gap;
        bit              drain;
    } t_page_ref;

    typedef struct {
        logic [ID_W-1:0]  entry_id;
        logic [POS_W-1:0] position;
        logic             was_hit;
        logic             evicted_valid;
        logic [ID_W-1:0]  evicted_id;
        logic             last_entry;
    } t_list_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [ID_W-1:0]   i_page_id = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [ID_W-1:0]   o_entry_id;
    logic [POS_W-1:0]  o_position;
    logic              o_was_hit;
    logic              o_evicted_valid;
    logic [ID_W-1:0]   o_evicted_id;
    logic              o_last_entry;

    t_page_ref         page_refs[$];
    logic [ID_W-1:0]   cached_ids[$];
    t_list_word        list_words[$];
    logic [ID_W-1:0]   id_pool[POOL_SIZE];
    logic [ID_W-1:0]   directed_ids[0:17];

    t_page_ref         next_ref;
    t_list_word        want;
    int                refs_offered = 0;
    int                refs_taken = 0;
    int                words_out = 0;
    int                words_seen = 0;
    int                idle_left = 0;
    int                rx_wait = 0;
    int                calm_left = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    int                idle_cycles = 0;
    int                fail_cnt = 0;

    lru_recency_cache #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_page_id      (i_page_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_entry_id     (o_entry_id),
        .o_position     (o_position),
        .o_was_hit      (o_was_hit),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_id   (o_evicted_id),
        .o_last_entry   (o_last_entry)
    );

    initial forever #5 i_clk = ~i_clk;

    // move the id to the newest end, drop the oldest on overflow, queue the whole list
    function automatic void predict_reference(logic [ID_W-1:0] id);
        int              hit_at;
        logic            gone_valid;
        logic [ID_W-1:0] gone_id;
        t_list_word      w;
        hit_at = -1;
        gone_valid = 1'b0;
        gone_id = '0;
        foreach (cached_ids[i]) begin
            if (cached_ids[i] == id) hit_at = i;
        end
        if (hit_at >= 0) cached_ids.delete(hit_at);
        cached_ids = {cached_ids, id};
        if (cached_ids.size() > CAPACITY) begin
            gone_valid = 1'b1;
            gone_id = cached_ids[0];
            cached_ids.delete(0);
        end
        foreach (cached_ids[i]) begin
            w.entry_id      = cached_ids[i];
            w.position      = POS_W'(i);
            w.was_hit       = (hit_at >= 0);
            w.evicted_valid = gone_valid;
            w.evicted_id    = gone_id;
            w.last_entry    = (i == cached_ids.size() - 1);
            list_words = {list_words, w};
        end
    endfunction

    function automatic void check_field(string name, logic [ID_W-1:0] exp_val,
                                        logic [ID_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_cnt++;
        end
    endfunction

    function automatic void add_ref(logic [ID_W-1:0] id, int gap, bit drain);
        t_page_ref r;
        r.id = id;
        r.gap = gap;
        r.drain = drain;
        page_refs = {page_refs, r};
    endfunction

    // mostly ids from a small pool so that hits and evictions both happen
    function automatic logic [ID_W-1:0] pick_page();
        if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return ID_W'($urandom);
    endfunction

    function automatic void refill_pool();
        foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || refs_taken == refs_offered) begin
            if (idle_left > 0) begin
                i_valid <= 1'b0;
                idle_left--;
            end else if (page_refs.size() != 0 &&
                         !(page_refs[0].drain && list_words.size() != 0)) begin
                next_ref = page_refs[0];
                page_refs.delete(0);
                i_valid <= 1'b1;
                i_page_id <= next_ref.id;
                refs_offered <= refs_offered + 1;
                idle_left = (page_refs.size() != 0) ? page_refs[0].gap : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            predict_reference(i_page_id);
            refs_taken <= refs_taken + 1;
        end
    end

    // output stall: per-word waits, calm stretches, one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && refs_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            if (words_seen != words_out) begin
                words_seen = words_out;
                if (calm_left > 0) begin
                    calm_left--;
                    rx_wait = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    calm_left = $urandom_range(15, 40);
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, 4);
                end
            end
            if (rx_wait > 0) begin
                i_stall <= 1'b1;
                rx_wait--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            words_out <= words_out + 1;
            if (list_words.size() == 0) begin
                $error("unexpected word: entry_id %0h position %0d", o_entry_id, o_position);
                fail_cnt++;
            end else begin
                want = list_words[0];
                list_words.delete(0);
                check_field("entry_id", want.entry_id, o_entry_id);
                check_field("position", ID_W'(want.position), ID_W'(o_position));
                check_field("was_hit", ID_W'(want.was_hit), ID_W'(o_was_hit));
                check_field("evicted_valid", ID_W'(want.evicted_valid), ID_W'(o_evicted_valid));
                check_field("evicted_id", want.evicted_id, o_evicted_id);
                check_field("last_entry", ID_W'(want.last_entry), ID_W'(o_last_entry));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        // empty cache, extremes, hit on newest, hit on oldest, fill, evict, hit in the middle
        directed_ids = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0000,
                         31'h2AAA_AAAA, 31'h5555_5555, 31'h0000_0001, 31'h4000_0000,
                         31'h2AAA_AAAA, 31'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                         31'h0000_0001, 31'h3FFF_FFFF, 31'h0000_0002, 31'h7FFF_FFFE,
                         31'h5555_5555, 31'h4000_0000};
        foreach (directed_ids[i]) add_ref(directed_ids[i], $urandom_range(0, 4), 1'b0);

        // back to back with no sender gaps
        refill_pool();
        add_ref(pick_page(), 0, 1'b1);
        repeat (79) add_ref(pick_page(), 0, 1'b0);

        // random gaps; the long output hold-off lands in here
        refill_pool();
        add_ref(pick_page(), $urandom_range(0, 4), 1'b1);
        repeat (69) add_ref(pick_page(), $urandom_range(0, 4), 1'b0);

        refill_pool();
        add_ref(pick_page(), $urandom_range(0, 4), 1'b1);
        repeat (59) begin
            add_ref(pick_page(), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4),
                    ($urandom_range(0, 19) == 0));
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (page_refs.size() != 0 || refs_taken != refs_offered || list_words.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
design/lru_pkg.sv
design/lru_cell.sv
design/lru_recency_cache.sv
sim/lru_recency_cache_test.sv
